FILE: rtl/core/cce_pkg.sv
`timescale 1ns / 1ps

package cce_pkg;

  // fixed field widths
  localparam int CORR_W = 16;
  localparam int PSI_W  = 21;
  localparam int INV_W  = 17;
  localparam int NVAR_W = 4;
  // variable index width inside the block, covers up to sixteen variables
  localparam int VIDX_W = 4;

  localparam logic [NVAR_W-1:0] NVAR_RESET = 4'd8;
  localparam logic [INV_W-1:0]  INV_RESET  = 17'd65536;

  localparam logic signed [CORR_W-1:0] ONE_Q14 = 16'sd16384;

  // register index codes on the config port
  localparam logic REG_NUM_VARIABLES = 1'b0;
  localparam logic REG_INVERSE_SIZE  = 1'b1;

  // one decoded item handed from the front end to the back end
  typedef struct packed {
    logic                     query;
    logic                     wr_en;
    logic                     err;
    logic                     diag;
    logic [VIDX_W-1:0]        e;
    logic [VIDX_W-1:0]        f;
    logic [VIDX_W-1:0]        g;
    logic [VIDX_W-1:0]        h;
    logic signed [CORR_W-1:0] value;
  } cmd_t;

endpackage

FILE: rtl/core/correlation_covariance_element.sv
`timescale 1ns / 1ps

// Element of Steiger's asymptotic covariance matrix of correlations. Write
// words (kind 0) load one Q2.14 entry of the correlation matrix at
// (var_row, var_col); the matrix is not mirrored, so both halves and the
// diagonal must be loaded, and every entry a query touches must be written
// first. Query words (kind 1) name two pair indices in row-major
// upper-triangle order over num_variables variables and return one result
// word: (1 - r^2)^2 for equal indices, else the four-term half-sum, times
// inverse_sample_size (unsigned Q1.16), rounded and saturated to Q4.16.
// An index not below p(p-1)/2 returns index_error with psi_value zero.
// Write words give no result. A front end decodes each word (pair index to
// variable pair, range check) into a two-entry queue, so the input keeps
// flowing while the back end works until the queue is full. An off-diagonal
// query costs the back end most, set by the single read port of the matrix
// memory (eight entries, one per cycle) and by the shared 16x16 factor
// multiplier and 32x32 product multiplier; an out-of-range query skips the
// arithmetic. A finished result sits in the output register while the back
// end starts the next word.
// Registers: num_variables at 0x0 (reset 8), inverse_sample_size at 0x4
// (reset 65536); write them only while the block is idle.

module correlation_covariance_element import cce_pkg::*; #(
  parameter int MAX_VARIABLES = 8,
  parameter int VAR_W  = $clog2(MAX_VARIABLES),
  parameter int PAIR_W = $clog2(MAX_VARIABLES * (MAX_VARIABLES - 1) / 2 + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  // config port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  // input words
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     kind,
  input  logic [VAR_W-1:0]         var_row,
  input  logic [VAR_W-1:0]         var_col,
  input  logic signed [CORR_W-1:0] corr_value,
  input  logic [PAIR_W-1:0]        pair_row,
  input  logic [PAIR_W-1:0]        pair_col,
  // result words
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [PSI_W-1:0]  psi_value,
  output logic                     index_error
);

  logic [NVAR_W-1:0] num_variables;
  logic [INV_W-1:0]  inverse_sample_size;
  logic              cfg_write;
  logic              reg_sel;

  logic queue_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic cmd_valid;
  cmd_t head;

  // config registers, zero wait states
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_variables       <= NVAR_RESET;
      inverse_sample_size <= INV_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_NUM_VARIABLES: num_variables       <= pwdata[NVAR_W-1:0];
        REG_INVERSE_SIZE:  inverse_sample_size <= pwdata[INV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_NUM_VARIABLES: prdata = 32'(num_variables);
      REG_INVERSE_SIZE:  prdata = 32'(inverse_sample_size);
      default:           prdata = '0;
    endcase
  end

  // front end: decode and range check
  cce_front #(
    .MAX_VARIABLES (MAX_VARIABLES),
    .VAR_W         (VAR_W),
    .PAIR_W        (PAIR_W)
  ) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .var_row       (var_row),
    .var_col       (var_col),
    .corr_value    (corr_value),
    .pair_row      (pair_row),
    .pair_col      (pair_col),
    .num_variables (num_variables),
    .queue_full    (queue_full),
    .push          (push),
    .cmd           (push_cmd)
  );

  // decoded words wait here for the back end
  cce_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (cmd_valid),
    .head      (head)
  );

  // back end: matrix memory, arithmetic sequencer, output register
  cce_back #(
    .MAX_VARIABLES (MAX_VARIABLES),
    .VAR_W         (VAR_W)
  ) u_back (
    .clk                 (clk),
    .rst                 (rst),
    .cmd_valid           (cmd_valid),
    .cmd                 (head),
    .cmd_pop             (pop),
    .inverse_sample_size (inverse_sample_size),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .psi_value           (psi_value),
    .index_error         (index_error)
  );

endmodule

FILE: rtl/core/cce_front.sv
`timescale 1ns / 1ps

module cce_front import cce_pkg::*; #(
  parameter int MAX_VARIABLES = 8,
  parameter int VAR_W         = 3,
  parameter int PAIR_W        = 5
) (
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     kind,
  input  logic [VAR_W-1:0]         var_row,
  input  logic [VAR_W-1:0]         var_col,
  input  logic signed [CORR_W-1:0] corr_value,
  input  logic [PAIR_W-1:0]        pair_row,
  input  logic [PAIR_W-1:0]        pair_col,
  input  logic [NVAR_W-1:0]        num_variables,
  input  logic                     queue_full,
  output logic                     push,
  output cmd_t                     cmd
);

  localparam int CNT_W = $clog2(MAX_VARIABLES * MAX_VARIABLES) + 1;
  localparam int P_W   = VIDX_W + 1;

  logic [P_W-1:0]   p;
  logic [CNT_W-1:0] pm1;
  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] zi;
  logic [CNT_W-1:0] zj;
  logic [CNT_W-1:0] z_hi;
  logic [CNT_W-1:0] z_lo;
  logic [2*VIDX_W-1:0] ef;
  logic [2*VIDX_W-1:0] gh;

  // pair index to (row, col) of the upper triangle, rows searched in parallel
  function automatic logic [2*VIDX_W-1:0] pair_of(input logic [CNT_W-1:0] z,
                                                  input logic [CNT_W-1:0] pm);
    logic [VIDX_W-1:0] e;
    logic [VIDX_W-1:0] f;
    logic [CNT_W-1:0]  st;
    logic [CNT_W-1:0]  st_e;
    e    = '0;
    st_e = '0;
    for (int a = 0; a < MAX_VARIABLES - 1; a++) begin
      st = CNT_W'(a) * pm - CNT_W'(a * (a - 1) / 2);
      if (CNT_W'(a) < pm && st <= z) begin
        e    = VIDX_W'(a);
        st_e = st;
      end
    end
    f = e + VIDX_W'(1) + VIDX_W'(z - st_e);
    return {e, f};
  endfunction

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    if ({1'b0, num_variables} > P_W'(MAX_VARIABLES)) p = P_W'(MAX_VARIABLES);
    else p = {1'b0, num_variables};
    pm1 = (p == '0) ? '0 : CNT_W'(p) - CNT_W'(1);
    k   = (CNT_W'(p) * pm1) >> 1;
    zi  = CNT_W'(pair_row);
    zj  = CNT_W'(pair_col);
    // larger index gives (e,f)
    if (zj > zi) begin
      z_hi = zj;
      z_lo = zi;
    end else begin
      z_hi = zi;
      z_lo = zj;
    end
    ef = pair_of(z_hi, pm1);
    gh = pair_of(z_lo, pm1);
  end

  always_comb begin
    cmd.query = kind;
    cmd.value = corr_value;
    cmd.wr_en = ({1'b0, var_row} < (VAR_W+1)'(MAX_VARIABLES)) &&
                ({1'b0, var_col} < (VAR_W+1)'(MAX_VARIABLES));
    cmd.err   = (zi >= k) || (zj >= k);
    cmd.diag  = (zi == zj);
    if (kind) begin
      cmd.e = ef[2*VIDX_W-1:VIDX_W];
      cmd.f = ef[VIDX_W-1:0];
      cmd.g = gh[2*VIDX_W-1:VIDX_W];
      cmd.h = gh[VIDX_W-1:0];
    end else begin
      cmd.e = VIDX_W'(var_row);
      cmd.f = VIDX_W'(var_col);
      cmd.g = '0;
      cmd.h = '0;
    end
  end

endmodule

FILE: rtl/core/cce_queue.sv
`timescale 1ns / 1ps

module cce_queue import cce_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t head
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  cmd_t             entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full      = (count == (PTR_W+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      if (push && !pop) count <= count + (PTR_W+1)'(1);
      else if (pop && !push) count <= count - (PTR_W+1)'(1);
    end
  end

endmodule

FILE: rtl/core/cce_back.sv
`timescale 1ns / 1ps

module cce_back import cce_pkg::*; #(
  parameter int MAX_VARIABLES = 8,
  parameter int VAR_W         = 3
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_valid,
  input  cmd_t                    cmd,
  output logic                    cmd_pop,
  input  logic [INV_W-1:0]        inverse_sample_size,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [PSI_W-1:0] psi_value,
  output logic                    index_error
);

  localparam int AW    = 2 * VAR_W;
  localparam int DEPTH = MAX_VARIABLES << VAR_W;
  localparam int FAC_W = 32;
  localparam int PRD_W = 64;
  localparam int ACC_W = 58;
  localparam int V16_W = 24;
  localparam int SCL_W = V16_W + INV_W + 1;

  localparam logic [1:0] SEL_E = 2'd0;
  localparam logic [1:0] SEL_F = 2'd1;
  localparam logic [1:0] SEL_G = 2'd2;
  localparam logic [1:0] SEL_H = 2'd3;

  // entries read per off-diagonal query: ef eg fg fh gh eh fe hg
  localparam logic [1:0] SLOT_ROW [8] = '{SEL_E, SEL_E, SEL_F, SEL_F,
                                          SEL_G, SEL_E, SEL_F, SEL_H};
  localparam logic [1:0] SLOT_COL [8] = '{SEL_F, SEL_G, SEL_G, SEL_H,
                                          SEL_H, SEL_H, SEL_E, SEL_G};
  // factor n is slot[A] - slot[B]*slot[C], products pair factors 2n and 2n+1
  localparam logic [2:0] FAC_A [8] = '{3'd1, 3'd3, 3'd5, 3'd2, 3'd1, 3'd3, 3'd5, 3'd2};
  localparam logic [2:0] FAC_B [8] = '{3'd0, 3'd2, 3'd1, 3'd6, 3'd5, 3'd6, 3'd0, 3'd3};
  localparam logic [2:0] FAC_C [8] = '{3'd2, 3'd4, 3'd4, 3'd1, 3'd7, 3'd5, 3'd3, 3'd7};

  localparam logic [3:0] N_READ_OFF = 4'd8;
  localparam logic [3:0] N_FAC_OFF  = 4'd8;
  localparam logic [3:0] N_PROD_OFF = 4'd4;

  localparam logic signed [ACC_W-1:0] HALF_DIAG = ACC_W'(1) << 31;
  localparam logic signed [ACC_W-1:0] HALF_OFF  = ACC_W'(1) << 32;
  localparam logic signed [SCL_W-1:0] HALF_SCL  = SCL_W'(1) << 15;
  localparam logic signed [SCL_W-1:0] SAT_HI    = SCL_W'(524287);
  localparam logic signed [SCL_W-1:0] SAT_LO    = -SCL_W'(524288);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_FACT  = 7'b0000100,
    S_PROD  = 7'b0001000,
    S_ROUND = 7'b0010000,
    S_SCALE = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t                    state;
  cmd_t                      cur;
  logic [3:0]                cnt;
  logic [3:0]                n_read;
  logic [3:0]                n_fac;
  logic [3:0]                n_prod;
  logic signed [CORR_W-1:0]  mem [DEPTH];
  logic [AW-1:0]             rd_addr;
  logic [AW-1:0]             wr_addr;
  logic signed [CORR_W-1:0]  rd_data;
  logic signed [CORR_W-1:0]  slot [8];
  logic signed [FAC_W-1:0]   fac [8];
  logic signed [CORR_W-1:0]  fa;
  logic signed [CORR_W-1:0]  fb;
  logic signed [CORR_W-1:0]  fc;
  logic signed [FAC_W-1:0]   bc;
  logic signed [FAC_W-1:0]   fac_next;
  logic signed [FAC_W-1:0]   px;
  logic signed [FAC_W-1:0]   py;
  logic signed [PRD_W-1:0]   prod;
  logic signed [PRD_W-1:0]   prod_sh;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_rnd;
  logic signed [ACC_W-1:0]   acc_sh;
  logic signed [V16_W-1:0]   v16;
  logic signed [SCL_W-1:0]   scaled;
  logic signed [SCL_W-1:0]   scl_sh;
  logic signed [PSI_W-1:0]   sat;
  logic                      out_free;

  function automatic logic [VAR_W-1:0] pick(input logic [1:0] sel, input cmd_t c);
    case (sel)
      SEL_E:   pick = c.e[VAR_W-1:0];
      SEL_F:   pick = c.f[VAR_W-1:0];
      SEL_G:   pick = c.g[VAR_W-1:0];
      SEL_H:   pick = c.h[VAR_W-1:0];
      default: pick = c.e[VAR_W-1:0];
    endcase
  endfunction

  assign out_free = !out_valid || !out_stall;
  assign cmd_pop  = (state == S_IDLE) && cmd_valid;

  assign n_read = cur.diag ? 4'd1 : N_READ_OFF;
  assign n_fac  = cur.diag ? 4'd1 : N_FAC_OFF;
  assign n_prod = cur.diag ? 4'd1 : N_PROD_OFF;

  assign wr_addr = {cmd.e[VAR_W-1:0], cmd.f[VAR_W-1:0]};
  assign rd_addr = {pick(SLOT_ROW[cnt[2:0]], cur), pick(SLOT_COL[cnt[2:0]], cur)};

  // matrix memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd_pop && !cmd.query && cmd.wr_en) mem[wr_addr] <= cmd.value;
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  // factor unit: a*one - b*c, exact in Q28; diagonal squares the one entry
  always_comb begin
    fa       = cur.diag ? ONE_Q14 : slot[FAC_A[cnt[2:0]]];
    fb       = slot[FAC_B[cnt[2:0]]];
    fc       = cur.diag ? slot[0] : slot[FAC_C[cnt[2:0]]];
    bc       = fb * fc;
    fac_next = {{2{fa[CORR_W-1]}}, fa, 14'b0} - bc;
  end

  always_comb begin
    px      = fac[{cnt[1:0], 1'b0}];
    py      = cur.diag ? fac[0] : fac[{cnt[1:0], 1'b1}];
    prod_sh = prod >>> 8;
    acc_rnd = acc + (cur.diag ? HALF_DIAG : HALF_OFF);
    acc_sh  = cur.diag ? (acc_rnd >>> 32) : (acc_rnd >>> 33);
    scl_sh  = (scaled + HALF_SCL) >>> 16;
    if (scl_sh > SAT_HI) sat = SAT_HI[PSI_W-1:0];
    else if (scl_sh < SAT_LO) sat = SAT_LO[PSI_W-1:0];
    else sat = scl_sh[PSI_W-1:0];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.query) cur <= cmd;
    if (state == S_READ && cnt != 4'd0) slot[3'(cnt - 4'd1)] <= rd_data;
    if (state == S_FACT) fac[cnt[2:0]] <= fac_next;
    if (state == S_FACT) acc <= '0;
    if (state == S_PROD) begin
      if (cnt < n_prod) prod <= px * py;
      if (cnt != 4'd0) acc <= acc + prod_sh[ACC_W-1:0];
    end
    if (state == S_ROUND) v16 <= acc_sh[V16_W-1:0];
    if (state == S_SCALE) scaled <= v16 * $signed({1'b0, inverse_sample_size});
    if (state == S_DONE && out_free) begin
      psi_value   <= cur.err ? '0 : sat;
      index_error <= cur.err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          if (cmd_pop && cmd.query) begin
            state <= cmd.err ? S_DONE : S_READ;
          end
        end
        S_READ: begin
          if (cnt == n_read) begin
            state <= S_FACT;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        S_FACT: begin
          if (cnt == n_fac - 4'd1) begin
            state <= S_PROD;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        S_PROD: begin
          if (cnt == n_prod) begin
            state <= S_ROUND;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        S_ROUND: state <= S_SCALE;
        S_SCALE: state <= S_DONE;
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/cce_checker.sv
`timescale 1ns / 1ps

module cce_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [20:0] psi_value,
  input logic               index_error
);

  // result word holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(psi_value) && $stable(index_error))
    else $error("result word changed while stalled");

  // an index error carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && index_error |-> psi_value == 21'sd0)
    else $error("index error with nonzero value");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word after reset");

endmodule

bind correlation_covariance_element cce_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .psi_value   (psi_value),
  .index_error (index_error)
);
